[rtl/ulsc_pkg.sv]
// Shared types, character codes and hex helpers for the command parser.
// Used by every file of the block except ulsc_if; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ulsc_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned StepW      = 3;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharL     = 8'h6C;
  localparam logic [7:0] CharE     = 8'h65;
  localparam logic [7:0] CharD     = 8'h64;
  localparam logic [7:0] CharS     = 8'h73;
  localparam logic [7:0] CharW     = 8'h77;
  localparam logic [7:0] CharT     = 8'h74;

  localparam logic KindTx  = 1'b0;
  localparam logic KindLed = 1'b1;

  // What the back end has to send for one accepted byte
  typedef enum logic [2:0] {
    OpEcho,    // echo the byte only
    OpLedCmd,  // echo, then space
    OpOther,   // echo, then LF CR
    OpSwt,     // echo, space, switch byte in hex, LED write, LF CR
    OpLedSet   // echo both hex digits, LED write, LF CR
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] rx;
    logic [7:0] hex1;
    logic [7:0] led;
  } cmd_t;

  // Anything outside 0-9 and A-E reads as F
  function automatic logic [3:0] hex_value(input logic [7:0] ch);
    logic [7:0] diff;
    diff = ch - 8'h37;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      return ch[3:0];
    end else if (ch >= 8'h41 && ch <= 8'h45) begin
      return diff[3:0];
    end
    return 4'hF;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) begin
      return 8'h30 + {4'h0, v};
    end
    return 8'h37 + {4'h0, v};
  endfunction

endpackage

`default_nettype wire

[rtl/ulsc_if.sv]
// Valid/ready channel interfaces for received bytes and for results.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface ulsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [7:0] switch_bits;

  modport source (output valid, output rx_byte, output switch_bits, input ready);
  modport sink   (input valid, input rx_byte, input switch_bits, output ready);
endinterface

interface ulsc_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] result_data;
  logic       last_result;

  modport source (output valid, output result_kind, output result_data,
                  output last_result, input ready);
  modport sink   (input valid, input result_kind, input result_data,
                  input last_result, output ready);
endinterface

`default_nettype wire

[rtl/uart_led_switch_command_parser_unit.sv]
// Top level of the serial command parser: front end, descriptor queue,
// back end. Uses ulsc_pkg, ulsc_if, ulsc_front, ulsc_fifo, ulsc_back.
`timescale 1ns / 1ps
`default_nettype none

// Parses "led XY" and "swt" commands from received bytes. A byte is taken
// in the cycle it is offered while the descriptor queue has room (the
// first hex digit after "led" is always taken, as it only gets stored).
// The back-end sequencer emits one result per clock while its output register
// is free or being taken; a byte yields 1 result for an echo, 2 for "led",
// 3 for an unknown word, 5 for the second hex digit and 7 for "swt". A result
// sits in the output register until taken while new bytes keep entering.
module uart_led_switch_command_parser_unit #(
  parameter int unsigned QueueDepth = ulsc_pkg::QueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ulsc_in_if.sink   in_i,
  ulsc_out_if.source out_o
);

  ulsc_pkg::cmd_t push_data, pop_data;
  logic           push_valid, push_ready, pop_valid, pop_ready;

  ulsc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_data_o  (push_data),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  ulsc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_data),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  ulsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_data_i  (pop_data),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

[rtl/ulsc_front.sv]
// Front end: accepts received bytes, tracks the command phase and
// classifies each byte into a command descriptor. Uses ulsc_pkg, ulsc_in_if.
`timescale 1ns / 1ps
`default_nettype none

module ulsc_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  ulsc_in_if.sink           in_i,
  output ulsc_pkg::cmd_t    push_data_o,
  output logic              push_valid_o,
  input  wire logic         push_ready_i
);

  typedef enum logic [2:0] {
    PhCmd1,
    PhCmd2,
    PhCmd3,
    PhHex1,
    PhHex2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] cmd1_q, cmd2_q, hex1_q;
  logic       accept;

  // The first hex digit is only stored, so it never waits on the queue
  assign in_i.ready   = (phase_q == PhHex1) || push_ready_i;
  assign accept       = in_i.valid && in_i.ready;
  assign push_valid_o = in_i.valid && (phase_q != PhHex1);

  always_comb begin
    push_data_o.op   = ulsc_pkg::OpEcho;
    push_data_o.rx   = in_i.rx_byte;
    push_data_o.hex1 = hex1_q;
    push_data_o.led  = in_i.switch_bits;
    phase_d          = PhCmd1;
    unique case (phase_q)
      PhCmd2: begin
        phase_d = PhCmd3;
      end
      PhCmd3: begin
        if (cmd1_q == ulsc_pkg::CharL && cmd2_q == ulsc_pkg::CharE &&
            in_i.rx_byte == ulsc_pkg::CharD) begin
          push_data_o.op = ulsc_pkg::OpLedCmd;
          phase_d        = PhHex1;
        end else if (cmd1_q == ulsc_pkg::CharS && cmd2_q == ulsc_pkg::CharW &&
                     in_i.rx_byte == ulsc_pkg::CharT) begin
          push_data_o.op = ulsc_pkg::OpSwt;
        end else begin
          push_data_o.op = ulsc_pkg::OpOther;
        end
      end
      PhHex1: begin
        phase_d = PhHex2;
      end
      PhHex2: begin
        push_data_o.op  = ulsc_pkg::OpLedSet;
        push_data_o.led = {ulsc_pkg::hex_value(hex1_q),
                           ulsc_pkg::hex_value(in_i.rx_byte)};
      end
      default: begin
        phase_d = PhCmd2;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhCmd1;
    end else if (accept) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (phase_q == PhCmd1) cmd1_q <= in_i.rx_byte;
      if (phase_q == PhCmd2) cmd2_q <= in_i.rx_byte;
      if (phase_q == PhHex1) hex1_q <= in_i.rx_byte;
    end
  end

endmodule

`default_nettype wire

[rtl/ulsc_fifo.sv]
// Short descriptor queue between the front and back ends.
// Uses ulsc_pkg for the descriptor type.
`timescale 1ns / 1ps
`default_nettype none

module ulsc_fifo #(
  parameter int unsigned Depth = ulsc_pkg::QueueDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ulsc_pkg::cmd_t  push_data_i,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  output ulsc_pkg::cmd_t       pop_data_o,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  ulsc_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

[rtl/ulsc_back.sv]
// Back end: steps through each descriptor and emits one result per clock
// into an output register, stalled while it holds a result not yet taken. Uses ulsc_pkg and ulsc_out_if.
`timescale 1ns / 1ps
`default_nettype none

module ulsc_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ulsc_pkg::cmd_t  pop_data_i,
  input  wire logic            pop_valid_i,
  output logic                 pop_ready_o,
  ulsc_out_if.source           out_o
);

  localparam int unsigned StepW = ulsc_pkg::StepW;

  ulsc_pkg::cmd_t   cur_q, src;
  logic             busy_q;
  logic [StepW-1:0] step_q, st;
  logic             have, adv;
  logic             gen_kind, gen_last;
  logic [7:0]       gen_data;
  logic             out_valid_q, out_kind_q, out_last_q;
  logic [7:0]       out_data_q;

  // Start a fresh descriptor straight from the queue head at step zero
  assign src         = busy_q ? cur_q : pop_data_i;
  assign st          = busy_q ? step_q : '0;
  assign have        = busy_q || pop_valid_i;
  assign adv         = have && (!out_valid_q || out_o.ready);
  assign pop_ready_o = adv && !busy_q;

  always_comb begin
    gen_kind = ulsc_pkg::KindTx;
    gen_data = src.rx;
    gen_last = 1'b0;
    unique case (src.op)
      ulsc_pkg::OpEcho: begin
        gen_last = 1'b1;
      end
      ulsc_pkg::OpLedCmd: begin
        if (st != '0) begin
          gen_data = ulsc_pkg::CharSpace;
          gen_last = 1'b1;
        end
      end
      ulsc_pkg::OpOther: begin
        unique case (st)
          3'd0:    gen_data = src.rx;
          3'd1:    gen_data = ulsc_pkg::CharLf;
          default: begin
            gen_data = ulsc_pkg::CharCr;
            gen_last = 1'b1;
          end
        endcase
      end
      ulsc_pkg::OpSwt: begin
        unique case (st)
          3'd0: gen_data = src.rx;
          3'd1: gen_data = ulsc_pkg::CharSpace;
          3'd2: gen_data = ulsc_pkg::hex_char(src.led[7:4]);
          3'd3: gen_data = ulsc_pkg::hex_char(src.led[3:0]);
          3'd4: begin
            gen_kind = ulsc_pkg::KindLed;
            gen_data = src.led;
          end
          3'd5: gen_data = ulsc_pkg::CharLf;
          default: begin
            gen_data = ulsc_pkg::CharCr;
            gen_last = 1'b1;
          end
        endcase
      end
      ulsc_pkg::OpLedSet: begin
        unique case (st)
          3'd0: gen_data = src.hex1;
          3'd1: gen_data = src.rx;
          3'd2: begin
            gen_kind = ulsc_pkg::KindLed;
            gen_data = src.led;
          end
          3'd3: gen_data = ulsc_pkg::CharLf;
          default: begin
            gen_data = ulsc_pkg::CharCr;
            gen_last = 1'b1;
          end
        endcase
      end
      default: begin
        gen_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
        busy_q      <= !gen_last;
        step_q      <= gen_last ? '0 : st + 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_kind_q <= gen_kind;
      out_data_q <= gen_data;
      out_last_q <= gen_last;
      if (!busy_q) cur_q <= pop_data_i;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.result_data = out_data_q;
  assign out_o.last_result = out_last_q;

`ifndef SYNTHESIS
  a_busy_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q != '0))
    else $error("descriptor in progress at step zero");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && gen_last) |=> !busy_q)
    else $error("sequencer still busy after final result");

  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ready_o |-> pop_valid_i)
    else $error("descriptor fetched from an empty queue");
`endif

endmodule

`default_nettype wire
